FILE: rtl/ple_pkg.sv
// shared types and codes for the positional list engine
`timescale 1ns / 1ps

package ple_pkg;

  typedef enum logic [2:0] {
    MODE_INSERT = 3'd0,
    MODE_DELETE = 3'd1,
    MODE_GET    = 3'd2,
    MODE_LOCATE = 3'd3,
    MODE_CLEAR  = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_SHIFT,
    ST_INS_DRAIN,
    ST_INS_PUT,
    ST_DEL_FETCH,
    ST_DEL_ELEM,
    ST_DEL_SHIFT,
    ST_GET_READ,
    ST_GET_CAP,
    ST_LOC_SCAN,
    ST_FINISH
  } state_e;

  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_INS,
    PTR_POS,
    PTR_ZERO,
    PTR_INC,
    PTR_DEC
  } ptr_op_e;

  typedef enum logic [1:0] {
    SH_NONE,
    SH_UP,
    SH_DOWN
  } shift_e;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC,
    CNT_ZERO
  } cnt_op_e;

  typedef struct packed {
    logic [2:0] mode;
    logic [6:0] position;
    logic [7:0] value;
  } in_word_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] element;
    logic [6:0] found_position;
    logic [6:0] count;
    logic       is_empty;
  } out_word_t;

  typedef struct packed {
    logic    req_load;
    status_e status_code;
    ptr_op_e ptr_op;
    logic    rd_en;
    shift_e  shift;
    logic    put_val;
    logic    cap_elem;
    logic    cap_found;
    cnt_op_e cnt_op;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic pos_ok_ins;
    logic pos_ok_acc;
    logic full;
    logic ins_more;
    logic ins_last;
    logic more;
    logic match;
    logic rd_vld;
    logic out_free;
  } stat_t;

endpackage

FILE: rtl/ple_datapath.sv
// element memory, pointers, count and result register of the list engine
`timescale 1ns / 1ps

module ple_datapath #(
  parameter int CAPACITY = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ple_pkg::in_word_t in_word_i,
  input  ple_pkg::cmd_t     cmd_i,
  output ple_pkg::stat_t    stat_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ple_pkg::out_word_t out_word_o
);
  import ple_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = ((CW > 7) ? CW : 7) + 1;

  logic [7:0]    mem_q [CAPACITY];
  logic [7:0]    rdata_q;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] ptr_q, ptr_d;
  logic [AW-1:0] rd_idx_q;
  logic          rd_vld_q;
  logic          pend_q;
  logic [AW-1:0] pend_addr_q;
  logic [6:0]    pos_q;
  logic [7:0]    val_q;
  status_e       res_status_q;
  logic [7:0]    res_elem_q;
  logic [6:0]    res_found_q;
  logic          out_valid_q;
  out_word_t     out_word_q;

  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic [XW-1:0] in_pos_x, pos_x_q, cnt_x, ptr_x;
  logic [CW-1:0] found_n;
  logic [CW+6:0] found_wide, count_wide;

  assign rd_addr  = ptr_q[AW-1:0];
  assign in_pos_x = XW'(in_word_i.position);
  assign pos_x_q  = XW'(pos_q);
  assign cnt_x    = XW'(count_q);
  assign ptr_x    = XW'(ptr_q);

  // status toward the controller
  always_comb begin
    stat_o.pos_ok_ins = (in_pos_x != '0) && (in_pos_x <= cnt_x + XW'(1));
    stat_o.pos_ok_acc = (in_pos_x != '0) && (in_pos_x <= cnt_x);
    stat_o.full       = (count_q == CW'(CAPACITY));
    stat_o.ins_more   = (in_pos_x <= cnt_x);
    stat_o.ins_last   = ((ptr_x + XW'(1)) == pos_x_q);
    stat_o.more       = (ptr_q < count_q);
    stat_o.match      = rd_vld_q && (rdata_q == val_q);
    stat_o.rd_vld     = rd_vld_q;
    stat_o.out_free   = !out_valid_q || !out_stall_i;
  end

  // write port: pending shift write first, then the inserted word
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pend_addr_q;
    wr_data = rdata_q;
    if (pend_q) begin
      wr_en = 1'b1;
    end else if (cmd_i.put_val) begin
      wr_en   = 1'b1;
      wr_addr = AW'(pos_x_q - XW'(1));
      wr_data = val_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_comb begin
    ptr_d = ptr_q;
    unique case (cmd_i.ptr_op)
      PTR_HOLD: ptr_d = ptr_q;
      PTR_INS:  ptr_d = count_q - CW'(1);
      PTR_POS:  ptr_d = CW'(in_pos_x - XW'(1));
      PTR_ZERO: ptr_d = '0;
      PTR_INC:  ptr_d = ptr_q + CW'(1);
      PTR_DEC:  ptr_d = ptr_q - CW'(1);
      default:  ptr_d = ptr_q;
    endcase
  end

  always_comb begin
    count_d = count_q;
    unique case (cmd_i.cnt_op)
      CNT_HOLD: count_d = count_q;
      CNT_INC:  count_d = count_q + CW'(1);
      CNT_DEC:  count_d = count_q - CW'(1);
      CNT_ZERO: count_d = '0;
      default:  count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ptr_q       <= '0;
      rd_vld_q    <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      ptr_q    <= ptr_d;
      rd_vld_q <= cmd_i.rd_en;
      pend_q   <= cmd_i.rd_en && (cmd_i.shift != SH_NONE);
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign found_n    = CW'(rd_idx_q) + CW'(1);
  assign found_wide = {7'd0, found_n};
  assign count_wide = {7'd0, count_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_idx_q    <= rd_addr;
      pend_addr_q <= (cmd_i.shift == SH_UP) ? rd_addr + AW'(1) : rd_addr - AW'(1);
    end
    if (cmd_i.req_load) begin
      pos_q        <= in_word_i.position;
      val_q        <= in_word_i.value;
      res_status_q <= cmd_i.status_code;
      res_elem_q   <= '0;
      res_found_q  <= '0;
    end
    if (cmd_i.cap_elem) begin
      res_elem_q <= rdata_q;
    end
    if (cmd_i.cap_found) begin
      res_found_q <= found_wide[6:0];
    end
    if (cmd_i.out_load) begin
      out_word_q.status         <= res_status_q;
      out_word_q.element        <= res_elem_q;
      out_word_q.found_position <= res_found_q;
      out_word_q.count          <= count_wide[6:0];
      out_word_q.is_empty       <= (count_q == '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  a_no_put_on_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !cmd_i.put_val)
    else $error("inserted word collides with a pending shift write");

  a_no_rw_same_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q && cmd_i.rd_en) |-> (pend_addr_q != rd_addr))
    else $error("shift read and write hit the same entry");

  a_cap_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cap_elem |-> rd_vld_q)
    else $error("element captured without a read in flight");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || !out_stall_i))
    else $error("result register overwritten while a word waits");

endmodule

FILE: rtl/ple_ctrl.sv
// request sequencer of the positional list engine
`timescale 1ns / 1ps

module ple_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic [2:0]     in_mode_i,
  output logic           in_stall_o,
  input  ple_pkg::stat_t stat_i,
  output ple_pkg::cmd_t  cmd_o
);
  import ple_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (in_mode_i)
            MODE_INSERT: begin
              if (!stat_i.pos_ok_ins || stat_i.full) state_d = ST_FINISH;
              else if (stat_i.ins_more)              state_d = ST_INS_SHIFT;
              else                                   state_d = ST_INS_PUT;
            end
            MODE_DELETE: state_d = stat_i.pos_ok_acc ? ST_DEL_FETCH : ST_FINISH;
            MODE_GET:    state_d = stat_i.pos_ok_acc ? ST_GET_READ : ST_FINISH;
            MODE_LOCATE: state_d = ST_LOC_SCAN;
            default:     state_d = ST_FINISH;
          endcase
        end
      end
      ST_INS_SHIFT: if (stat_i.ins_last) state_d = ST_INS_DRAIN;
      ST_INS_DRAIN: state_d = ST_INS_PUT;
      ST_INS_PUT:   state_d = ST_FINISH;
      ST_DEL_FETCH: state_d = ST_DEL_ELEM;
      ST_DEL_ELEM:  state_d = stat_i.more ? ST_DEL_SHIFT : ST_FINISH;
      ST_DEL_SHIFT: if (!stat_i.more) state_d = ST_FINISH;
      ST_GET_READ:  state_d = ST_GET_CAP;
      ST_GET_CAP:   state_d = ST_FINISH;
      ST_LOC_SCAN: begin
        if (stat_i.match) begin
          state_d = ST_FINISH;
        end else if (!stat_i.more && !stat_i.rd_vld) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH:    if (stat_i.out_free) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o             = '0;
    cmd_o.status_code = STAT_OK;
    cmd_o.ptr_op      = PTR_HOLD;
    cmd_o.shift       = SH_NONE;
    cmd_o.cnt_op      = CNT_HOLD;
    in_stall_o        = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o     = 1'b0;
        cmd_o.req_load = in_valid_i;
        if (in_valid_i) begin
          unique case (in_mode_i)
            MODE_INSERT: begin
              if (!stat_i.pos_ok_ins) cmd_o.status_code = STAT_RANGE;
              else if (stat_i.full)   cmd_o.status_code = STAT_FULL;
              else if (stat_i.ins_more) cmd_o.ptr_op = PTR_INS;
            end
            MODE_DELETE, MODE_GET: begin
              if (!stat_i.pos_ok_acc) cmd_o.status_code = STAT_RANGE;
              else                    cmd_o.ptr_op      = PTR_POS;
            end
            MODE_LOCATE: cmd_o.ptr_op = PTR_ZERO;
            MODE_CLEAR:  cmd_o.cnt_op = CNT_ZERO;
            default:     cmd_o.cnt_op = CNT_HOLD;
          endcase
        end
      end
      ST_INS_SHIFT: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.shift  = SH_UP;
        cmd_o.ptr_op = stat_i.ins_last ? PTR_HOLD : PTR_DEC;
      end
      ST_INS_DRAIN: cmd_o.ptr_op = PTR_HOLD;
      ST_INS_PUT: begin
        cmd_o.put_val = 1'b1;
        cmd_o.cnt_op  = CNT_INC;
      end
      ST_DEL_FETCH: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.ptr_op = PTR_INC;
      end
      ST_DEL_ELEM: begin
        cmd_o.cap_elem = 1'b1;
        if (stat_i.more) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.shift  = SH_DOWN;
          cmd_o.ptr_op = PTR_INC;
        end else begin
          cmd_o.cnt_op = CNT_DEC;
        end
      end
      ST_DEL_SHIFT: begin
        if (stat_i.more) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.shift  = SH_DOWN;
          cmd_o.ptr_op = PTR_INC;
        end else begin
          cmd_o.cnt_op = CNT_DEC;
        end
      end
      ST_GET_READ: cmd_o.rd_en = 1'b1;
      ST_GET_CAP:  cmd_o.cap_elem = 1'b1;
      ST_LOC_SCAN: begin
        if (stat_i.match) begin
          cmd_o.cap_found = 1'b1;
        end else if (stat_i.more) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.ptr_op = PTR_INC;
        end
      end
      ST_FINISH: cmd_o.out_load = stat_i.out_free;
      default:   cmd_o.out_load = 1'b0;
    endcase
  end

endmodule

FILE: rtl/positional_list_engine.sv
// top level of the positional list engine: sequencer plus element datapath
//
//   channel  direction  handshake                payload
//   in       input      in_valid_i / in_stall_o   in_word_i  (mode, position, value)
//   out      output     out_valid_o / out_stall_i out_word_o (status, element,
//                                                  found_position, count, is_empty)
//
// one request at a time, one memory word per cycle; with n stored words and position p
// an insert shifts words p to n up one place, a delete shifts words p + 1 to n down one
// place, and a locate scans from position 1 up to the first hit or the end of the list
// the result sits in an output register, so the next request is taken while it waits
// reset clears the sequencer, count, pointer and valid flags; the memory has no reset
// a stalled result holds only the finish step of the following request
`timescale 1ns / 1ps

module positional_list_engine #(
  parameter int CAPACITY = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ple_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ple_pkg::out_word_t out_word_o
);
  import ple_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  ple_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_mode_i  (in_word_i.mode),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ple_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

FILE: tb/tb_positional_list_engine.sv
// testbench for the positional list engine: random and directed list requests checked
// against a cycle-free list predictor
`timescale 1ns / 1ps

module tb_positional_list_engine;
  import ple_pkg::*;

  localparam int CAPACITY     = 64;
  localparam int RANDOM_ITEMS = 900;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int SETTLE       = 2 * CAPACITY + 16;

  localparam logic [2:0] MODE_RSVD0 = 3'd5;
  localparam logic [2:0] MODE_RSVD1 = 3'd6;
  localparam logic [2:0] MODE_RSVD2 = 3'd7;

  typedef enum int {MIX_GROW, MIX_SHRINK, MIX_EVEN} mix_e;
  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_LONG} stall_style_e;

  typedef struct packed {
    logic     hold_off;
    in_word_t word;
  } feed_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_word_t  in_word_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_word_t out_word_o;

  feed_t     request_feed[$];
  out_word_t reply_fifo[$];

  logic [7:0] list_mem [CAPACITY];
  int         list_len    = 0;
  int         gen_len     = 0;
  int         queued_total = 0;
  int         fail_count  = 0;
  int         words_seen  = 0;
  int         cycle_count = 0;

  int           gap_left   = 0;
  int           burst_left = 1;
  int           phase_left = 0;
  int           hold_left  = 0;
  stall_style_e stall_style = STALL_NONE;

  positional_list_engine #(
    .CAPACITY(CAPACITY)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic out_word_t list_apply(in_word_t w);
    out_word_t r;
    int p;
    int k;
    r = '0;
    p = int'(w.position);
    case (w.mode)
      MODE_INSERT: begin
        if (p < 1 || p > list_len + 1) begin
          r.status = STAT_RANGE;
        end else if (list_len >= CAPACITY) begin
          r.status = STAT_FULL;
        end else begin
          for (k = list_len; k > p - 1; k--) list_mem[k] = list_mem[k - 1];
          list_mem[p - 1] = w.value;
          list_len++;
        end
      end
      MODE_DELETE: begin
        if (p < 1 || p > list_len) begin
          r.status = STAT_RANGE;
        end else begin
          r.element = list_mem[p - 1];
          for (k = p - 1; k + 1 < list_len; k++) list_mem[k] = list_mem[k + 1];
          list_len--;
        end
      end
      MODE_GET: begin
        if (p < 1 || p > list_len) r.status = STAT_RANGE;
        else r.element = list_mem[p - 1];
      end
      MODE_LOCATE: begin
        for (k = 0; k < list_len && r.found_position == '0; k++) begin
          if (list_mem[k] == w.value) r.found_position = 7'(k + 1);
        end
      end
      MODE_CLEAR: begin
        list_len = 0;
      end
      default: begin
      end
    endcase
    r.count    = 7'(list_len);
    r.is_empty = (list_len == 0);
    return r;
  endfunction

  task automatic report_mismatch(string what, int want, int got);
    $display("word %0d: %s expected %0h got %0h", words_seen, what, want, got);
    fail_count++;
  endtask

  task automatic queue_request(logic [2:0] m, int pos, int v);
    feed_t f;
    f.hold_off      = 1'b0;
    f.word.mode     = m;
    f.word.position = 7'(pos);
    f.word.value    = 8'(v);
    request_feed.push_back(f);
    queued_total++;
    case (m)
      MODE_INSERT: if (pos >= 1 && pos <= gen_len + 1 && gen_len < CAPACITY) gen_len++;
      MODE_DELETE: if (pos >= 1 && pos <= gen_len) gen_len--;
      MODE_CLEAR:  gen_len = 0;
      default: begin
      end
    endcase
  endtask

  task automatic push_hold_off();
    feed_t f;
    f = '0;
    f.hold_off = 1'b1;
    request_feed.push_back(f);
  endtask

  task automatic queue_random(mix_e mix, bit narrow);
    int roll;
    int ins_w;
    int del_w;
    int hi;
    int pos;
    int v;
    logic [2:0] m;
    case (mix)
      MIX_GROW:   begin ins_w = 55; del_w = 10; end
      MIX_SHRINK: begin ins_w = 20; del_w = 45; end
      default:    begin ins_w = 35; del_w = 30; end
    endcase
    roll = $urandom_range(99);
    if (roll < ins_w) m = MODE_INSERT;
    else if (roll < ins_w + del_w) m = MODE_DELETE;
    else if (roll < 80) m = MODE_GET;
    else if (roll < 95) m = MODE_LOCATE;
    else if (roll < 97) m = MODE_CLEAR;
    else m = 3'($urandom_range(MODE_RSVD0, MODE_RSVD2));
    hi = (m == MODE_INSERT) ? gen_len + 1 : gen_len;
    roll = $urandom_range(99);
    if (roll < 6) pos = 0;
    else if (roll < 12) pos = hi + 1;
    else if (roll < 16) pos = $urandom_range(127);
    else if (hi == 0) pos = 1;
    else if (roll < 30) pos = 1;
    else if (roll < 44) pos = hi;
    else pos = $urandom_range(1, hi);
    if (narrow) begin
      case ($urandom_range(3))
        0: v = 8'h00;
        1: v = 8'hff;
        2: v = 8'h5a;
        default: v = 8'h3c;
      endcase
    end else begin
      v = $urandom_range(255);
    end
    queue_request(m, pos, v);
  endtask

  // fill to capacity, poke the full list, then trim both ends
  task automatic queue_fill_cycle();
    queue_request(MODE_CLEAR, $urandom_range(127), $urandom_range(255));
    while (gen_len < CAPACITY) begin
      queue_request(MODE_INSERT, $urandom_range(1, gen_len + 1), $urandom_range(255));
    end
    queue_request(MODE_INSERT, CAPACITY + 1, $urandom_range(255));
    queue_request(MODE_INSERT, 1, $urandom_range(255));
    queue_request(MODE_INSERT, CAPACITY + 2, $urandom_range(255));
    queue_request(MODE_GET, CAPACITY, 0);
    queue_request(MODE_GET, CAPACITY + 1, 0);
    queue_request(MODE_LOCATE, 0, $urandom_range(255));
    queue_request(MODE_DELETE, CAPACITY, 0);
    queue_request(MODE_DELETE, 1, 0);
  endtask

  // driver
  always @(posedge clk_i) begin
    feed_t f;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) reply_fifo.push_back(list_apply(in_word_i));
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left != 0) begin
          gap_left   <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (request_feed.size() != 0 && request_feed[0].hold_off) begin
          in_valid_i <= 1'b0;
          if (reply_fifo.size() == 0) f = request_feed.pop_front();
        end else if (request_feed.size() != 0) begin
          f = request_feed.pop_front();
          in_word_i  <= f.word;
          in_valid_i <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= ($urandom_range(3) == 0) ? $urandom_range(40, 150)
                                                   : $urandom_range(1, 8);
            case ($urandom_range(9))
              0, 1, 2: gap_left <= 0;
              3, 4:    gap_left <= $urandom_range(5, 40);
              default: gap_left <= $urandom_range(1, 4);
            endcase
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver stall
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (phase_left == 0) begin
        stall_style <= stall_style_e'($urandom_range(3));
        phase_left  <= $urandom_range(40, 300);
      end else begin
        phase_left <= phase_left - 1;
      end
      if (hold_left != 0) begin
        hold_left   <= hold_left - 1;
        out_stall_i <= 1'b1;
      end else begin
        case (stall_style)
          STALL_NONE:  out_stall_i <= 1'b0;
          STALL_LIGHT: out_stall_i <= ($urandom_range(7) == 0);
          STALL_HEAVY: out_stall_i <= 1'($urandom_range(1));
          default: begin
            if ($urandom_range(15) == 0) begin
              hold_left   <= $urandom_range(5, 30);
              out_stall_i <= 1'b1;
            end else begin
              out_stall_i <= 1'b0;
            end
          end
        endcase
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (reply_fifo.size() == 0) begin
        report_mismatch("unexpected word", 0, int'(out_word_o));
      end else begin
        want = reply_fifo.pop_front();
        if (out_word_o.status !== want.status)
          report_mismatch("status", want.status, out_word_o.status);
        if (out_word_o.element !== want.element)
          report_mismatch("element", want.element, out_word_o.element);
        if (out_word_o.found_position !== want.found_position)
          report_mismatch("found_position", want.found_position, out_word_o.found_position);
        if (out_word_o.count !== want.count)
          report_mismatch("count", want.count, out_word_o.count);
        if (out_word_o.is_empty !== want.is_empty)
          report_mismatch("is_empty", want.is_empty, out_word_o.is_empty);
      end
      words_seen++;
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int target;
    int fills;
    int next_fill;
    int n;
    int i;
    mix_e mix;
    bit narrow;

    queue_request(MODE_GET, 1, 0);
    queue_request(MODE_DELETE, 0, 0);
    queue_request(MODE_INSERT, 0, 8'h11);
    queue_request(MODE_INSERT, 2, 8'h22);
    queue_request(MODE_LOCATE, 0, 8'h00);
    queue_request(MODE_RSVD0, 1, 8'h00);
    queue_request(MODE_RSVD1, 127, 8'hff);
    queue_request(MODE_RSVD2, 0, 8'h00);
    queue_request(MODE_INSERT, 1, 8'h00);
    queue_request(MODE_INSERT, 1, 8'hff);
    queue_request(MODE_INSERT, 3, 8'h5a);
    queue_request(MODE_INSERT, 2, 8'ha5);
    queue_request(MODE_GET, 4, 0);
    queue_request(MODE_GET, 5, 0);
    queue_request(MODE_GET, 127, 8'hff);
    queue_request(MODE_LOCATE, 0, 8'h5a);
    queue_request(MODE_LOCATE, 0, 8'h33);
    queue_request(MODE_LOCATE, 127, 8'hff);
    queue_request(MODE_DELETE, 1, 0);
    queue_request(MODE_DELETE, 3, 0);
    queue_request(MODE_DELETE, 3, 0);
    queue_request(MODE_INSERT, 4, 8'h77);
    queue_request(MODE_CLEAR, 0, 0);
    queue_request(MODE_GET, 1, 0);
    queue_request(MODE_DELETE, 1, 0);
    push_hold_off();

    target    = queued_total + RANDOM_ITEMS;
    fills     = 0;
    next_fill = queued_total;
    while (queued_total < target) begin
      if (fills < 2 && queued_total >= next_fill) begin
        queue_fill_cycle();
        fills++;
        next_fill = next_fill + 400;
      end
      mix    = mix_e'($urandom_range(2));
      narrow = 1'($urandom_range(1));
      n      = $urandom_range(15, 60);
      for (i = 0; i < n; i++) queue_random(mix, narrow);
      if ($urandom_range(3) == 0) push_hold_off();
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (request_feed.size() != 0 || in_valid_i) @(posedge clk_i);
    while (reply_fifo.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
